>>> rtl/core/psd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the point-to-segment distance pipeline.
package psd_pkg;
    localparam int COORD_BITS_DEF  = 16;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int DIST_BITS       = 17;
    localparam int PROJ_BITS       = 17;
endpackage

>>> rtl/core/psd_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider computing the unclamped projection quotient.
module psd_divider #(
    parameter int NUM_BITS = 34,
    parameter int TF       = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [NUM_BITS-1:0] i_den,
    output logic [TF:0]         o_quot
);
    logic [NUM_BITS:0]   r_rem [TF+1];
    logic [NUM_BITS-1:0] r_den [TF+1];
    logic [TF:0]         r_q   [TF+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num};
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar g = 0; g < TF; g++) begin : g_step
        logic [NUM_BITS+1:0] w_sh;
        logic [NUM_BITS+1:0] w_df;
        assign w_sh = {r_rem[g], 1'b0};
        assign w_df = w_sh - {2'b00, r_den[g]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1] <= r_den[g];
                if (!w_df[NUM_BITS+1]) begin
                    r_rem[g+1] <= w_df[NUM_BITS:0];
                    r_q[g+1]   <= {r_q[g][TF-1:0], 1'b1};
                end else begin
                    r_rem[g+1] <= w_sh[NUM_BITS:0];
                    r_q[g+1]   <= {r_q[g][TF-1:0], 1'b0};
                end
            end
        end
    end

    assign o_quot = r_q[TF];
endmodule

>>> rtl/core/psd_isqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one result bit per stage.
module psd_isqrt #(
    parameter int IN_BITS = 36
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [IN_BITS-1:0]   i_val,
    output logic [IN_BITS/2-1:0] o_root
);
    localparam int N  = (IN_BITS + 1) / 2;
    localparam int RW = 2 * N;

    logic [RW-1:0] r_v   [N+1];
    logic [RW-1:0] r_rem [N+1];
    logic [N-1:0]  r_res [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]   <= RW'(i_val);
            r_rem[0] <= '0;
            r_res[0] <= '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        logic [RW+1:0] w_rem;
        logic [RW+1:0] w_trial;
        logic [RW+1:0] w_df;
        assign w_rem   = {r_rem[g], r_v[g][RW-1 -: 2]};
        assign w_trial = {(RW-N)'(0), r_res[g], 2'b01};
        assign w_df    = w_rem - w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g+1] <= {r_v[g][RW-3:0], 2'b00};
                if (!w_df[RW+1]) begin
                    r_rem[g+1] <= w_df[RW-1:0];
                    r_res[g+1] <= {r_res[g][N-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= w_rem[RW-1:0];
                    r_res[g+1] <= {r_res[g][N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_res[N][IN_BITS/2-1:0];
endmodule

>>> rtl/core/point_segment_distance.sv
`timescale 1ns / 1ps
// Point-to-segment distance, top level.
// Accepts one transaction per cycle while the skid register is empty; the pipeline
// depth is set by the divider and square-root stages.
// When the output stalls, one more finished result moves into a skid register and
// then the whole pipeline holds, so input ready drops only while that register is
// full. Coordinates are signed Q8.8; distance is unsigned Q9.8; projection has
// T_FRAC_BITS fraction bits.
module point_segment_distance #(
    parameter int COORD_BITS  = psd_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // point_x, point_y, start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // distance, projection from the lowest bit up
    output logic [((COORD_BITS+T_FRAC_BITS+9)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                    m_axis_tuser
);
    import psd_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int D   = C + 1;
    localparam int P   = 2 * D;
    localparam int NB  = P + 1;
    localparam int TF  = T_FRAC_BITS;
    localparam int TW  = TF + 1;
    localparam int MW  = TW + D + 1;
    localparam int RWD = D + 2;
    localparam int SQB = 2 * RWD + 1;
    localparam int SQE = SQB + (SQB % 2);
    localparam int DB  = SQE / 2;
    localparam int OD  = DB + TW;
    localparam int OW  = ((D + TW + 7) / 8) * 8;
    localparam int LAT = 8 + TF + DB;

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_ONE  = 2'd1;
    localparam logic [1:0] SEL_DIV  = 2'd2;

    logic w_en;
    logic r_skid_v, r_out_v;
    logic [LAT-1:0] r_vld;
    logic w_pipe_out_v;

    assign w_en = !r_skid_v;
    assign s_axis_tready = !r_skid_v;

    logic signed [C-1:0] w_px, w_py, w_sx, w_sy, w_ex, w_ey;
    assign w_px = s_axis_tdata[0*C +: C];
    assign w_py = s_axis_tdata[1*C +: C];
    assign w_sx = s_axis_tdata[2*C +: C];
    assign w_sy = s_axis_tdata[3*C +: C];
    assign w_ex = s_axis_tdata[4*C +: C];
    assign w_ey = s_axis_tdata[5*C +: C];

    // Stage 1: differences.
    logic signed [D-1:0] r1_dx, r1_dy, r1_wx, r1_wy;
    logic signed [C-1:0] r1_px, r1_py, r1_sx, r1_sy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= D'(w_ex) - D'(w_sx);
            r1_dy <= D'(w_ey) - D'(w_sy);
            r1_wx <= D'(w_px) - D'(w_sx);
            r1_wy <= D'(w_py) - D'(w_sy);
            r1_px <= w_px; r1_py <= w_py; r1_sx <= w_sx; r1_sy <= w_sy;
        end
    end

    // Stage 2: products.
    logic signed [P-1:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [D-1:0] r2_dx, r2_dy;
    logic signed [C-1:0] r2_px, r2_py, r2_sx, r2_sy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a <= r1_wx * r1_dx;
            r2_b <= r1_wy * r1_dy;
            r2_c <= r1_dx * r1_dx;
            r2_d <= r1_dy * r1_dy;
            r2_dx <= r1_dx; r2_dy <= r1_dy;
            r2_px <= r1_px; r2_py <= r1_py; r2_sx <= r1_sx; r2_sy <= r1_sy;
        end
    end

    // Stage 3: dot products, case selection.
    logic signed [NB-1:0] w_num;
    logic [NB-1:0] w_den;
    assign w_num = NB'(r2_a) + NB'(r2_b);
    assign w_den = NB'($unsigned(r2_c)) + NB'($unsigned(r2_d));

    logic [NB-1:0] r3_num, r3_den;
    logic [1:0] r3_sel;
    logic r3_degen;
    logic signed [D-1:0] r3_dx, r3_dy;
    logic signed [C-1:0] r3_px, r3_py, r3_sx, r3_sy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_num   <= w_num;
            r3_den   <= w_den;
            r3_degen <= (w_den == '0);
            if (w_den == '0 || w_num <= 0) r3_sel <= SEL_ZERO;
            else if ($unsigned(w_num) >= w_den) r3_sel <= SEL_ONE;
            else r3_sel <= SEL_DIV;
            r3_dx <= r2_dx; r3_dy <= r2_dy;
            r3_px <= r2_px; r3_py <= r2_py; r3_sx <= r2_sx; r3_sy <= r2_sy;
        end
    end

    logic [TF:0] w_quot;
    psd_divider #(.NUM_BITS(NB), .TF(TF)) u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r3_num),
        .i_den (r3_den),
        .o_quot(w_quot)
    );

    // Side-band delay alongside the divider.
    localparam int SB = 2 + 2 * D + 4 * C;
    logic [SB-1:0] r_sd [TF+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= {r3_sel, r3_dx, r3_dy, r3_px, r3_py, r3_sx, r3_sy};
            for (int k = 0; k < TF; k++) r_sd[k+1] <= r_sd[k];
        end
    end
    logic [SB-1:0] w_sdv;
    assign w_sdv = r_sd[TF];
    logic r_dg [TF+4];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dg[0] <= r3_degen;
            for (int k = 0; k < TF + 3; k++) r_dg[k+1] <= r_dg[k];
        end
    end

    logic [1:0] w_sel;
    logic signed [D-1:0] w_dx, w_dy;
    logic signed [C-1:0] w_ppx, w_ppy, w_ssx, w_ssy;
    assign {w_sel, w_dx, w_dy, w_ppx, w_ppy, w_ssx, w_ssy} = w_sdv;

    logic [TW-1:0] w_t;
    always_comb begin
        case (w_sel)
            SEL_ZERO: w_t = '0;
            SEL_ONE:  w_t = TW'(1) << TF;
            default:  w_t = w_quot;
        endcase
    end

    // Stage 4: offsets t*d.
    logic signed [MW-1:0] r4_mx, r4_my;
    logic [TW-1:0] r4_t;
    logic signed [C-1:0] r4_px, r4_py, r4_sx, r4_sy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_mx <= $signed({1'b0, w_t}) * w_dx;
            r4_my <= $signed({1'b0, w_t}) * w_dy;
            r4_t <= w_t;
            r4_px <= w_ppx; r4_py <= w_ppy; r4_sx <= w_ssx; r4_sy <= w_ssy;
        end
    end

    // Stage 5: residual vector (arithmetic shift is floor).
    logic signed [RWD-1:0] r5_rx, r5_ry;
    logic [TW-1:0] r5_t;
    logic signed [MW-1:0] w_fx, w_fy;
    assign w_fx = r4_mx >>> TF;
    assign w_fy = r4_my >>> TF;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_rx <= RWD'(r4_sx) + RWD'(w_fx) - RWD'(r4_px);
            r5_ry <= RWD'(r4_sy) + RWD'(w_fy) - RWD'(r4_py);
            r5_t  <= r4_t;
        end
    end

    // Stage 6: squares.
    logic signed [2*RWD-1:0] w_rx2, w_ry2;
    assign w_rx2 = r5_rx * r5_rx;
    assign w_ry2 = r5_ry * r5_ry;

    logic [2*RWD-1:0] r6_sx, r6_sy;
    logic [TW-1:0] r6_t;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sx <= $unsigned(w_rx2);
            r6_sy <= $unsigned(w_ry2);
            r6_t  <= r5_t;
        end
    end

    logic [SQB-1:0] w_sq;
    assign w_sq = SQB'(r6_sx) + SQB'(r6_sy);

    logic [DB-1:0] w_root;
    psd_isqrt #(.IN_BITS(SQE)) u_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_val (SQE'(w_sq)),
        .o_root(w_root)
    );

    logic [TW:0] r_td [DB+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_td[0] <= {r_dg[TF+3], r6_t};
            for (int k = 0; k < DB; k++) r_td[k+1] <= r_td[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid && s_axis_tready};
        end
    end
    assign w_pipe_out_v = r_vld[LAT-1];

    // Output register plus skid slot.
    logic [OD:0] w_res, r_out_d, r_skid_d;
    assign w_res = {r_td[DB], w_root};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || m_axis_tready) begin
                if (r_skid_v) begin
                    r_out_v <= 1'b1; r_out_d <= r_skid_d; r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= w_en && w_pipe_out_v;
                    r_out_d <= w_res;
                end
            end else if (w_en && w_pipe_out_v) begin
                r_skid_v <= 1'b1; r_skid_d <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OW'({r_out_d[OD-1:DB], r_out_d[D-1:0]});
    assign m_axis_tuser  = r_out_d[OD];
endmodule
